/* rtl/core/sli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Shared word types, operation and status codes, and the command and status
// bundles between the sorted list controller and its datapath.
// ----------------------------------------------------------------------------
package sli_pkg;

	// operation codes carried in the request word
	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_READOUT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] value;
	} req_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] entry;
		logic [3:0]         count;
		logic               last;
	} rsp_word_t;

	// controller to datapath
	typedef struct packed {
		logic    load_val;   // capture request value
		logic    idx_to_cnt; // idx <= count
		logic    idx_clr;    // idx <= 0
		logic    idx_dec;
		logic    idx_inc;
		logic    wp_clr;
		logic    wp_inc;
		logic    rd_prev;    // read mem[idx-1]
		logic    rd_idx;     // read mem[idx]
		logic    wr_shift;   // mem[idx] <= read data
		logic    wr_val;     // mem[idx] <= value
		logic    wr_keep;    // mem[wp] <= read data
		logic    cnt_inc;
		logic    cnt_to_wp;
		logic    out_entry;  // load result register with read data
		logic    out_status; // load result register with a status-only word
		status_t out_code;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cnt_full;
		logic cnt_zero;
		logic idx_zero;
		logic idx_at_cnt;
		logic wp_at_cnt;
		logic wp_zero;
		logic rd_gt;      // signed read data above value
		logic rd_ne;      // read data differs from value
		logic entry_last; // idx is the final entry
		logic out_free;   // result register can take a word this cycle
	} dp_sts_t;

endpackage

/* rtl/core/sorted_list_insert_delete_top.sv */
`timescale 1ns / 1ps
// An insert walks down from the top, shifting each larger entry up, until a compare stops
// it or it reaches the bottom; a delete visits every stored entry; then the list is emitted
// word by word, or a status-only word is sent, before the controller returns to idle.
// Full and empty answers go straight to the status-only word. Each step is an address state
// and a check state on the registered read; a stalled result word holds the controller.
// Reset clears the entry count, the controller and the result valid; entries are not cleared.
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_top
// Ascending list of signed words with insert, delete-all-matches and readout,
// each successful operation answering with the full list.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_top
	import sli_pkg::*;
#(
	parameter int CAPACITY = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	sli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.opcode    (req.opcode),
		.sts       (sts),
		.cmd       (cmd)
	);

	sli_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (req.value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

/* rtl/core/sli_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_dp
// Sorted list datapath: entry memory with registered read, index, write
// pointer and count registers, and the result register toward the output.
// ----------------------------------------------------------------------------
module sli_dp
	import sli_pkg::*;
#(
	parameter int CAPACITY = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	input  logic      [31:0] value,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   val_q;
	logic [31:0]   rdata_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] wp_q;
	logic [CW-1:0] idx_m1;
	logic [CW-1:0] idx_p1;
	logic          out_vld_q;
	rsp_word_t     out_q;
	logic          out_free;

	assign idx_m1   = idx_q - CW'(1);
	assign idx_p1   = idx_q + CW'(1);
	assign out_free = !out_vld_q || !rsp_stall;

	// report conditions to the controller
	always_comb begin
		sts.cnt_full   = (cnt_q == CW'(CAPACITY));
		sts.cnt_zero   = (cnt_q == '0);
		sts.idx_zero   = (idx_q == '0);
		sts.idx_at_cnt = (idx_q == cnt_q);
		sts.wp_at_cnt  = (wp_q == cnt_q);
		sts.wp_zero    = (wp_q == '0);
		sts.rd_gt      = ($signed(rdata_q) > $signed(val_q));
		sts.rd_ne      = (rdata_q != val_q);
		sts.entry_last = (idx_p1 == cnt_q);
		sts.out_free   = out_free;
	end

	// entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_shift) begin
			mem[idx_q[AW-1:0]] <= rdata_q;
		end else if (cmd.wr_val) begin
			mem[idx_q[AW-1:0]] <= val_q;
		end else if (cmd.wr_keep) begin
			mem[wp_q[AW-1:0]] <= rdata_q;
		end
		if (cmd.rd_prev) begin
			rdata_q <= mem[idx_m1[AW-1:0]];
		end else if (cmd.rd_idx) begin
			rdata_q <= mem[idx_q[AW-1:0]];
		end
	end

	// hold the operand
	always_ff @(posedge clk) begin
		if (cmd.load_val) begin
			val_q <= value;
		end
	end

	// advance index, write pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			wp_q  <= '0;
		end else begin
			if (cmd.idx_to_cnt) begin
				idx_q <= cnt_q;
			end else if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_m1;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1;
			end
			if (cmd.wp_clr) begin
				wp_q <= '0;
			end else if (cmd.wp_inc) begin
				wp_q <= wp_q + CW'(1);
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_to_wp) begin
				cnt_q <= wp_q;
			end
		end
	end

	// result register: load a word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_entry || cmd.out_status) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_entry) begin
			out_q.status <= ST_OK;
			out_q.entry  <= rdata_q;
			out_q.count  <= 4'(cnt_q);
			out_q.last   <= sts.entry_last;
		end else if (cmd.out_status) begin
			out_q.status <= cmd.out_code;
			out_q.entry  <= '0;
			out_q.count  <= 4'(cnt_q);
			out_q.last   <= 1'b1;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

endmodule

/* rtl/core/sli_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_ctrl
// Sorted list controller: sequences the insert shift, the delete compaction
// and the word-by-word list readout through the datapath.
// ----------------------------------------------------------------------------
module sli_ctrl
	import sli_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] opcode,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_INS_RD  = 8'b0000_0010,
		S_INS_CHK = 8'b0000_0100,
		S_DEL_RD  = 8'b0000_1000,
		S_DEL_CHK = 8'b0001_0000,
		S_OUT_RD  = 8'b0010_0000,
		S_OUT_LD  = 8'b0100_0000,
		S_RES     = 8'b1000_0000
	} state_t;

	state_t  state_q;
	state_t  state_d;
	status_t code_q;
	status_t code_d;
	logic    accept;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d      = state_q;
		code_d       = code_q;
		cmd          = '0;
		cmd.out_code = code_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_val = 1'b1;
					case (opcode)
						OP_INSERT: begin
							if (sts.cnt_full) begin
								code_d  = ST_FULL;
								state_d = S_RES;
							end else begin
								cmd.idx_to_cnt = 1'b1;
								state_d        = S_INS_RD;
							end
						end
						OP_DELETE: begin
							if (sts.cnt_zero) begin
								code_d  = ST_EMPTY;
								state_d = S_RES;
							end else begin
								cmd.idx_clr = 1'b1;
								cmd.wp_clr  = 1'b1;
								state_d     = S_DEL_RD;
							end
						end
						OP_READOUT: begin
							if (sts.cnt_zero) begin
								code_d  = ST_EMPTY;
								state_d = S_RES;
							end else begin
								cmd.idx_clr = 1'b1;
								state_d     = S_OUT_RD;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			// walk down from the top, shifting larger entries up by one
			S_INS_RD: begin
				if (sts.idx_zero) begin
					cmd.wr_val  = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = S_OUT_RD;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = S_INS_CHK;
				end
			end
			S_INS_CHK: begin
				if (sts.rd_gt) begin
					cmd.wr_shift = 1'b1;
					cmd.idx_dec  = 1'b1;
					state_d      = S_INS_RD;
				end else begin
					cmd.wr_val  = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = S_OUT_RD;
				end
			end
			// compact: copy every non-matching entry down to the write pointer
			S_DEL_RD: begin
				if (sts.idx_at_cnt) begin
					if (sts.wp_at_cnt) begin
						code_d  = ST_NOT_FOUND;
						state_d = S_RES;
					end else if (sts.wp_zero) begin
						cmd.cnt_to_wp = 1'b1;
						code_d        = ST_OK;
						state_d       = S_RES;
					end else begin
						cmd.cnt_to_wp = 1'b1;
						cmd.idx_clr   = 1'b1;
						state_d       = S_OUT_RD;
					end
				end else begin
					cmd.rd_idx = 1'b1;
					state_d    = S_DEL_CHK;
				end
			end
			S_DEL_CHK: begin
				if (sts.rd_ne) begin
					cmd.wr_keep = 1'b1;
					cmd.wp_inc  = 1'b1;
				end
				cmd.idx_inc = 1'b1;
				state_d     = S_DEL_RD;
			end
			// emit the list one word at a time
			S_OUT_RD: begin
				cmd.rd_idx = 1'b1;
				state_d    = S_OUT_LD;
			end
			S_OUT_LD: begin
				if (sts.out_free) begin
					cmd.out_entry = 1'b1;
					if (sts.entry_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_OUT_RD;
					end
				end
			end
			S_RES: begin
				if (sts.out_free) begin
					cmd.out_status = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

/* tb/tb_sorted_list_insert_delete_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_delete_top
// Drives insert, delete and readout requests into the sorted list and checks
// every response word against a local model of the ascending list. It covers
// empty, full, not-found, duplicate and extreme-value cases first, then runs
// random traffic with sender bursts, receiver stalls and a drain pause.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_delete_top;
	import sli_pkg::*;

	localparam int LIST_CAP = 10;
	localparam int IDLE_LIMIT = 2000;
	localparam int END_CYCLES = 60;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_STRETCH
	} stall_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	// local copy of the list and the words it should produce
	logic signed [31:0] list_model [LIST_CAP];
	int unsigned        list_len = 0;
	rsp_word_t          expected_words [$];

	int          fail_count = 0;
	int          quiet_cycles = 0;
	int          stall_run = 0;
	stall_mode_t stall_mode = STALL_NONE;

	sorted_list_insert_delete_top #(
		.CAPACITY(LIST_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// list model
	// ------------------------------------------------------------------------
	function automatic rsp_word_t make_word(status_t st, logic signed [31:0] e, logic fin);
		rsp_word_t w;
		w.status = st;
		w.entry = e;
		w.count = list_len[3:0];
		w.last = fin;
		return w;
	endfunction

	// queue the whole list, or one status word when it is empty
	function automatic void expect_list(status_t empty_st);
		if (list_len == 0) begin
			expected_words.push_back(make_word(empty_st, '0, 1'b1));
		end else begin
			for (int unsigned i = 0; i < list_len; i++)
				expected_words.push_back(make_word(ST_OK, list_model[i], i + 1 == list_len));
		end
	endfunction

	function automatic void apply_request(req_word_t w);
		int unsigned pos;
		int unsigned keep;
		case (op_t'(w.opcode))
			OP_INSERT: begin
				if (list_len >= LIST_CAP) begin
					expected_words.push_back(make_word(ST_FULL, '0, 1'b1));
				end else begin
					// place after any equal entries
					pos = 0;
					while (pos < list_len && list_model[pos] <= w.value)
						pos++;
					for (int unsigned i = list_len; i > pos; i--)
						list_model[i] = list_model[i - 1];
					list_model[pos] = w.value;
					list_len++;
					expect_list(ST_OK);
				end
			end
			OP_DELETE: begin
				if (list_len == 0) begin
					expected_words.push_back(make_word(ST_EMPTY, '0, 1'b1));
				end else begin
					// compact, dropping every match
					keep = 0;
					for (int unsigned i = 0; i < list_len; i++) begin
						if (list_model[i] != w.value) begin
							list_model[keep] = list_model[i];
							keep++;
						end
					end
					if (keep == list_len) begin
						expected_words.push_back(make_word(ST_NOT_FOUND, '0, 1'b1));
					end else begin
						list_len = keep;
						expect_list(ST_OK);
					end
				end
			end
			OP_READOUT: expect_list(ST_EMPTY);
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// response check
	// ------------------------------------------------------------------------
	function automatic void compare_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: status %0d entry %0d count %0d last %0d",
					rsp.status, rsp.entry, rsp.count, rsp.last);
				fail_count++;
			end else begin
				want = expected_words.pop_front();
				compare_field("status", want.status, rsp.status);
				compare_field("entry", want.entry, rsp.entry);
				compare_field("count", want.count, rsp.count);
				compare_field("last", want.last, rsp.last);
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			case (stall_mode)
				STALL_NONE: rsp_stall <= 1'b0;
				STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 35);
				default: begin
					// hold each level for a random stretch
					if (stall_run == 0) begin
						rsp_stall <= ~rsp_stall;
						stall_run <= $urandom_range(1, 8);
					end else begin
						stall_run <= stall_run - 1;
					end
				end
			endcase
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------
	task automatic send_word(input req_word_t w);
		req_valid <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (req_stall);
		apply_request(w);
	endtask

	task automatic send_op(input op_t op, input logic signed [31:0] v);
		req_word_t w;
		w.opcode = op;
		w.value = v;
		send_word(w);
	endtask

	task automatic idle_sender(input int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] random_value();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				// narrow pool so duplicates and hits are common
				v = $urandom_range(0, 15);
				return v - 8;
			end
			4: begin
				case ($urandom_range(0, 3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic req_word_t random_word(input int insert_pct);
		req_word_t w;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		w.value = random_value();
		if (roll < 3) begin
			w.opcode = OP_NONE;
		end else if (roll < 13) begin
			w.opcode = OP_READOUT;
		end else if ($urandom_range(0, 99) < insert_pct) begin
			w.opcode = OP_INSERT;
		end else begin
			w.opcode = OP_DELETE;
			// mostly aim deletes at stored values
			if (list_len != 0 && $urandom_range(0, 99) < 70)
				w.value = list_model[$urandom_range(0, list_len - 1)];
		end
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_empty_list();
		send_op(OP_READOUT, VAL_MAX);
		send_op(OP_DELETE, 0);
		send_op(OP_NONE, $urandom);
	endtask

	task automatic test_extremes_and_duplicates();
		send_op(OP_INSERT, VAL_MAX);
		send_op(OP_INSERT, VAL_MIN);
		send_op(OP_INSERT, 0);
		send_op(OP_INSERT, -1);
		send_op(OP_INSERT, 5);
		send_op(OP_INSERT, 5);
		send_op(OP_READOUT, 0);
		send_op(OP_DELETE, 7);
		send_op(OP_DELETE, 5);
	endtask

	task automatic test_fill_to_full();
		repeat (6) send_op(OP_INSERT, 100);
		send_op(OP_INSERT, 3);
	endtask

	task automatic test_delete_to_empty();
		send_op(OP_DELETE, 100);
		send_op(OP_DELETE, VAL_MAX);
		send_op(OP_DELETE, VAL_MIN);
		send_op(OP_DELETE, 0);
		send_op(OP_DELETE, -1);
	endtask

	task automatic test_pause_until_drained();
		send_op(OP_READOUT, 0);
		wait_drained();
		send_op(OP_READOUT, 0);
	endtask

	task automatic test_random_traffic(input int n_items, input int insert_pct,
			input bit use_gaps, input stall_mode_t mode);
		req_word_t w;
		int sent;
		int burst_left;
		sent = 0;
		burst_left = 0;
		stall_mode = mode;
		while (sent < n_items) begin
			if (use_gaps && burst_left == 0) begin
				idle_sender($urandom_range(1, 6));
				burst_left = $urandom_range(1, 10);
			end
			w = random_word(insert_pct);
			send_word(w);
			if (w.opcode != OP_NONE)
				sent++;
			if (burst_left > 0)
				burst_left--;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		stall_mode = STALL_RANDOM;
		test_empty_list();
		test_extremes_and_duplicates();
		test_fill_to_full();
		test_delete_to_empty();

		test_random_traffic(45, 75, 1'b0, STALL_NONE);
		test_random_traffic(45, 30, 1'b1, STALL_RANDOM);
		test_pause_until_drained();
		test_random_traffic(45, 60, 1'b1, STALL_STRETCH);
		test_random_traffic(45, 45, 1'b1, STALL_RANDOM);

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/sli_pkg.sv
rtl/core/sli_dp.sv
rtl/core/sli_ctrl.sv
rtl/core/sorted_list_insert_delete_top.sv
tb/tb_sorted_list_insert_delete_top.sv
